/* design/pitot_airspeed_estimator_unit_macros.svh */
// ----------------------------------------------------------------------------
// pitot_airspeed_estimator_unit_macros
// assertion macros for the airspeed estimator
// ----------------------------------------------------------------------------
`ifndef PITOT_AIRSPEED_ESTIMATOR_UNIT_MACROS_SVH
`define PITOT_AIRSPEED_ESTIMATOR_UNIT_MACROS_SVH

// property must hold in the cycle after the trigger
`define PAE_ASSERT_NEXT(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("assertion failed");

// property must hold in the same cycle as the trigger
`define PAE_ASSERT_NOW(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("assertion failed");

`endif

/* design/pae_pkg.sv */
// ----------------------------------------------------------------------------
// pae_pkg
// shared types and constants of the pitot airspeed estimator
// ----------------------------------------------------------------------------
package pae_pkg;

  localparam int MaxSamples   = 255;
  localparam int PressureBits = 20;

  localparam logic [1:0] CfgSensorPresent = 2'd0;
  localparam logic [1:0] CfgComputePeriod = 2'd1;
  localparam logic [1:0] CfgPublishPeriod = 2'd2;
  localparam logic [1:0] CfgAlpha         = 2'd3;

  localparam logic OpSample = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [PressureBits-1:0] diff_pressure;
    logic [15:0]             temperature_centik;
    logic [16:0]             static_pressure_pa;
  } in_item_t;

  typedef struct packed {
    logic [15:0] airspeed_cms;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // control between the sequencer and the serial divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

/* design/pae_if.sv */
// ----------------------------------------------------------------------------
// pae_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface pae_if #(type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/pae_div.sv */
// ----------------------------------------------------------------------------
// pae_div
// restoring divider, one quotient bit per cycle, unsigned
// ----------------------------------------------------------------------------
module pae_div (
  input  logic              clk,
  input  logic              rst,
  input  pae_pkg::div_req_t req,
  output pae_pkg::div_rsp_t rsp
);
  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  always_comb begin
    trial = {rem[31:0], quo[63]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = '{done: done, quotient: quo};
endmodule

/* design/pae_sqrt.sv */
// ----------------------------------------------------------------------------
// pae_sqrt
// digit-by-digit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module pae_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] val;
  logic [33:0] rem;
  logic [31:0] res;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] shifted;
  logic [33:0] trial;

  always_comb begin
    shifted = {rem[31:0], val[63:62]};
    trial   = shifted - {res, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        val  <= radicand;
        rem  <= '0;
        res  <= '0;
        cnt  <= 6'd0;
      end else if (busy) begin
        val <= {val[61:0], 2'b00};
        if (!trial[33]) begin
          rem <= trial;
          res <= {res[30:0], 1'b1};
        end else begin
          rem <= shifted;
          res <= {res[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign root = res;
endmodule

/* design/pae_mul.sv */
// ----------------------------------------------------------------------------
// pae_mul
// shift-and-add multiplier, one multiplier bit per cycle, unsigned
// ----------------------------------------------------------------------------
module pae_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] mcand,
  input  logic [31:0] mplier,
  output logic        done,
  output logic [79:0] product
);
  logic [31:0] mp;
  logic [79:0] mc;
  logic [5:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        mp      <= mplier;
        mc      <= {32'd0, mcand};
        product <= '0;
        cnt     <= 6'd0;
      end else if (busy) begin
        if (mp[0]) begin
          product <= product + mc;
        end
        mp  <= {1'b0, mp[31:1]};
        mc  <= {mc[78:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* design/pitot_airspeed_estimator_unit.sv */
// ----------------------------------------------------------------------------
// pitot_airspeed_estimator_unit
// averages differential pressure and turns it into smoothed airspeed
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_ch   | in  | op, diff_pressure, temperature_centik, static_pressure_pa
// out_ch  | out | airspeed_cms
// cfg_ch  | in  | index, data
// samples and ticks that compute nothing are handled in S_IDLE alone
// computing ticks run three 64-step divides, one 32-step root and three
// 32-step multiplies, each with a start and a wait state, plus accept and finish
// reset is synchronous; one item is worked on at a time
// a result waits in the output register while later items are taken; a tick
// that publishes again stalls in its last state until that result is taken
`include "pitot_airspeed_estimator_unit_macros.svh"
module pitot_airspeed_estimator_unit (
  input logic clk,
  input logic rst,
  pae_if.sink   in_ch,
  pae_if.sink   cfg_ch,
  pae_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_AVG, S_AVG_W, S_MT, S_MT_W, S_QD, S_QD_W, S_SQ, S_SQ_W,
    S_MK, S_MK_W, S_K640, S_K640_W, S_MA, S_MA_W, S_FIN
  } state_t;

  state_t state;
  logic        sensor_present;
  logic [7:0]  compute_period;
  logic [15:0] publish_period;
  logic [15:0] alpha;
  logic signed [31:0] psum;
  logic [7:0]  scount;
  logic [7:0]  ctick;
  logic [15:0] ptick;
  logic signed [31:0] smooth;
  logic [15:0] temp;
  logic [16:0] pstat;
  logic        neg;
  logic [63:0] work;
  logic        dneg;

  pae_pkg::div_req_t dreq;
  pae_pkg::div_rsp_t drsp;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic        m_start, m_done;
  logic [47:0] m_a;
  logic [31:0] m_b;
  logic [79:0] m_p;

  pae_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  pae_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .radicand(work),
    .done(sq_done), .root(sq_root));
  pae_mul u_mul (.clk(clk), .rst(rst), .start(m_start), .mcand(m_a), .mplier(m_b),
    .done(m_done), .product(m_p));

  logic [7:0]  ctick_inc;
  logic [15:0] ptick_inc;
  logic [7:0]  cper;
  logic signed [33:0] diff_q8;
  logic signed [33:0] sm_sum;
  logic signed [31:0] sm_sat;
  logic signed [23:0] o_div;
  logic [31:0] sum_mag;

  assign ctick_inc = (ctick == 8'hff) ? ctick : ctick + 8'd1;
  assign ptick_inc = (ptick == 16'hffff) ? ptick : ptick + 16'd1;
  assign cper      = (compute_period == 8'd0) ? 8'd1 : compute_period;
  assign sum_mag   = psum[31] ? 32'(-psum) : 32'(psum);

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sensor_present <= 1'b1;
      compute_period <= 8'd20;
      publish_period <= 16'd200;
      alpha          <= 16'd6554;
      psum           <= '0;
      scount         <= '0;
      ctick          <= '0;
      ptick          <= '0;
      smooth         <= '0;
      out_ch.valid   <= 1'b0;
      dreq.start     <= 1'b0;
      sq_start       <= 1'b0;
      m_start        <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      sq_start   <= 1'b0;
      m_start    <= 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.data.index)
          {1'b0, pae_pkg::CfgSensorPresent}: sensor_present <= cfg_ch.data.data[0];
          {1'b0, pae_pkg::CfgComputePeriod}: compute_period <= cfg_ch.data.data[7:0];
          {1'b0, pae_pkg::CfgPublishPeriod}: publish_period <= cfg_ch.data.data[15:0];
          {1'b0, pae_pkg::CfgAlpha}:         alpha <= cfg_ch.data.data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (in_ch.data.op == pae_pkg::OpSample) begin
              if (scount < 8'(pae_pkg::MaxSamples)) begin
                psum   <= psum + 32'(signed'(in_ch.data.diff_pressure));
                scount <= scount + 8'd1;
              end
            end else begin
              ctick <= ctick_inc;
              ptick <= ptick_inc;
              temp  <= in_ch.data.temperature_centik;
              pstat <= (in_ch.data.static_pressure_pa == 17'd0) ? 17'd1
                       : in_ch.data.static_pressure_pa;
              if (sensor_present && ctick_inc >= cper) begin
                ctick <= '0;
                if (scount != 8'd0) begin
                  state <= S_AVG;
                end
              end
            end
          end
        end
        S_AVG: begin
          neg           <= psum[31];
          dreq.dividend <= {32'd0, sum_mag};
          dreq.divisor  <= {24'd0, scount};
          dreq.start    <= 1'b1;
          state         <= S_AVG_W;
        end
        S_AVG_W: begin
          if (drsp.done) begin
            psum   <= '0;
            scount <= '0;
            m_a    <= {16'd0, drsp.quotient[31:0]};
            m_b    <= {16'd0, temp};
            state  <= S_MT;
          end
        end
        S_MT: begin
          m_start <= 1'b1;
          state   <= S_MT_W;
        end
        S_MT_W: begin
          if (m_done) begin
            dreq.dividend <= {m_p[55:0], 8'd0};
            dreq.divisor  <= {15'd0, pstat};
            state         <= S_QD;
          end
        end
        S_QD: begin
          dreq.start <= 1'b1;
          state      <= S_QD_W;
        end
        S_QD_W: begin
          if (drsp.done) begin
            work  <= drsp.quotient;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq_start <= 1'b1;
          state    <= S_SQ_W;
        end
        S_SQ_W: begin
          if (sq_done) begin
            m_a   <= {16'd0, sq_root};
            m_b   <= 32'd2396;
            state <= S_MK;
          end
        end
        S_MK: begin
          m_start <= 1'b1;
          state   <= S_MK_W;
        end
        S_MK_W: begin
          if (m_done) begin
            dreq.dividend <= m_p[63:0];
            dreq.divisor  <= 32'd640;
            state         <= S_K640;
          end
        end
        S_K640: begin
          dreq.start <= 1'b1;
          state      <= S_K640_W;
        end
        S_K640_W: begin
          if (drsp.done) begin
            // speed fits 26 bits; diff = speed*256 - smooth
            work  <= 64'(signed'(diff_q8));
            state <= S_MA;
          end
        end
        S_MA: begin
          dneg    <= work[63];
          m_a     <= work[63] ? 48'(-work) : work[47:0];
          m_b     <= {16'd0, alpha};
          m_start <= 1'b1;
          state   <= S_MA_W;
        end
        S_MA_W: begin
          if (m_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (ptick > publish_period) begin
            // wait while the previous result is still held
            if (!out_ch.valid || out_ch.ready) begin
              smooth       <= sm_sat;
              ptick        <= '0;
              out_ch.valid <= 1'b1;
              out_ch.data.airspeed_cms <= (o_div > 24'sd32767) ? 16'sd32767
                : (o_div < -24'sd32768) ? -16'sd32768 : o_div[15:0];
              state        <= S_IDLE;
            end
          end else begin
            smooth <= sm_sat;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic signed [35:0] speed_s;
  logic signed [49:0] delta;
  always_comb begin
    speed_s = neg ? -36'(signed'({1'b0, drsp.quotient[33:0]}))
                  : 36'(signed'({1'b0, drsp.quotient[33:0]}));
    diff_q8 = 34'(speed_s <<< 8) - 34'(smooth);
    delta   = dneg ? -50'(signed'({1'b0, m_p[63:16]})) : 50'(signed'({1'b0, m_p[63:16]}));
    sm_sum  = 34'(smooth) + 34'(delta);
    if (sm_sum > 34'sh7fffffff) begin
      sm_sat = 32'sh7fffffff;
    end else if (sm_sum < -34'sh80000000) begin
      sm_sat = 32'sh80000000;
    end else begin
      sm_sat = sm_sum[31:0];
    end
    o_div = 24'(sm_sat[31] ? -((-33'(sm_sat)) >>> 8) : (sm_sat >>> 8));
  end

  `PAE_ASSERT_NEXT(a_out_holds, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `PAE_ASSERT_NOW(a_no_take_busy, clk, rst, state != S_IDLE, !in_ch.ready)
  `PAE_ASSERT_NOW(a_count_max, clk, rst, 1'b1, scount <= 8'(pae_pkg::MaxSamples))
endmodule
